FILE: rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg: shared types and constants for the font handle cache
// Field widths, the default table depth, and the structs that pass between
// the controller and the row of entry cells.
// ----------------------------------------------------------------------------
package fhc_pkg;

  localparam int DEFAULT_ENTRIES = 8;
  localparam int KEY_W           = 32;
  localparam int HANDLE_W        = 16;

  // probe that walks the cell row, one cell per cycle
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [HANDLE_W-1:0] handle;
  } probe_t;

  // per-cell update strobes from the controller
  typedef struct packed {
    logic wr;     // load the new pair into this cell
    logic shift;  // load the pair held by the next-younger neighbor
  } cell_ctl_t;

  // controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

FILE: rtl/fhc_if.sv
// ----------------------------------------------------------------------------
// fhc_if: request and response channels of the font handle cache
// Valid/ready channels; an item moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface fhc_req_if
  import fhc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    font_number;
  logic [HANDLE_W-1:0] fresh_handle;
  logic                open_ok;

  modport source (output valid, output font_number, output fresh_handle,
                  output open_ok, input ready);
  modport sink   (input valid, input font_number, input fresh_handle,
                  input open_ok, output ready);
endinterface

interface fhc_rsp_if
  import fhc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [HANDLE_W-1:0] handle_out;
  logic                failed;
  logic                evict_valid;
  logic [HANDLE_W-1:0] evicted_handle;

  modport source (output valid, output hit, output handle_out, output failed,
                  output evict_valid, output evicted_handle, input ready);
  modport sink   (input valid, input hit, input handle_out, input failed,
                  input evict_valid, input evicted_handle, output ready);
endinterface

FILE: rtl/fhc_cell.sv
// ----------------------------------------------------------------------------
// fhc_cell: one entry of the cache row
// Holds a key/handle pair, checks the passing probe against it, and hands
// the probe on to the next cell. On replacement it takes its neighbor's pair.
// ----------------------------------------------------------------------------
module fhc_cell
  import fhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [KEY_W-1:0]    key,
  input  logic                occupied,
  input  probe_t              probe_in,
  output probe_t              probe_out,
  input  cell_ctl_t           ctl,
  input  logic [KEY_W-1:0]    new_key,
  input  logic [HANDLE_W-1:0] new_handle,
  input  logic [KEY_W-1:0]    nbr_key,
  input  logic [HANDLE_W-1:0] nbr_handle,
  output logic [KEY_W-1:0]    entry_key,
  output logic [HANDLE_W-1:0] entry_handle
);

  logic   match;
  probe_t probe_next;

  // compare only an occupied entry; first match along the row wins
  assign match = occupied && (entry_key == key) && !probe_in.hit;

  always_comb begin
    probe_next = probe_in;
    if (match) begin
      probe_next.hit    = 1'b1;
      probe_next.handle = entry_handle;
    end
  end

  // probe stage
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.hit    <= probe_next.hit;
    probe_out.handle <= probe_next.handle;
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_key    <= nbr_key;
      entry_handle <= nbr_handle;
    end else if (ctl.wr) begin
      entry_key    <= new_key;
      entry_handle <= new_handle;
    end
  end

endmodule

FILE: rtl/fifo_handle_cache_core.sv
// ----------------------------------------------------------------------------
// fifo_handle_cache_core: fully associative font handle cache, FIFO replace
// Top level: request latch, probe launch, result decision and table update.
// ----------------------------------------------------------------------------
// One request is handled at a time. The probe passes one entry cell per
// cycle, and a new request is accepted only after the previous result has
// been loaded into the output register; the length of the cell row sets
// how long each request takes. Cells are kept in age order, the
// oldest in cell 0: a fill writes the first free cell, and a replacement on
// a full table shifts the row one place toward cell 0, reports the handle
// dropped from cell 0 and puts the new pair in the last cell. A finished
// response sits in an output register, so the next request is taken while
// it waits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fifo_handle_cache_core
  import fhc_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input logic      clk,
  input logic      rst,
  fhc_req_if.sink  req,
  fhc_rsp_if.source rsp
);

  localparam int OCC_W = $clog2(ENTRIES + 1);

  state_t              state;
  state_t              state_next;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] fresh_r;
  logic                ok_r;
  logic                go;
  probe_t              fin;
  logic [OCC_W-1:0]    occ;
  logic [OCC_W-1:0]    occ_next;

  probe_t              probe      [ENTRIES+1];
  cell_ctl_t           ctl        [ENTRIES];
  logic [KEY_W-1:0]    cell_key   [ENTRIES];
  logic [HANDLE_W-1:0] cell_handle[ENTRIES];

  logic req_fire;
  logic out_load;
  logic full;
  logic insert;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign full      = (occ == OCC_W'(ENTRIES));
  assign insert    = out_load && !fin.hit && ok_r;

  // probe launch into the first cell
  assign probe[0] = '{valid: go, hit: 1'b0, handle: '0};

  // cell row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]    nbr_key;
    logic [HANDLE_W-1:0] nbr_handle;

    if (i == ENTRIES - 1) begin : g_last
      assign nbr_key    = key_r;
      assign nbr_handle = fresh_r;
    end else begin : g_mid
      assign nbr_key    = cell_key[i+1];
      assign nbr_handle = cell_handle[i+1];
    end

    assign ctl[i].wr    = insert && !full && (occ == OCC_W'(i));
    assign ctl[i].shift = insert && full;

    fhc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .key          (key_r),
      .occupied     (OCC_W'(i) < occ),
      .probe_in     (probe[i]),
      .probe_out    (probe[i+1]),
      .ctl          (ctl[i]),
      .new_key      (key_r),
      .new_handle   (fresh_r),
      .nbr_key      (nbr_key),
      .nbr_handle   (nbr_handle),
      .entry_key    (cell_key[i]),
      .entry_handle (cell_handle[i])
    );
  end

  // controller
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_fire) state_next = S_WALK;
      S_WALK: if (probe[ENTRIES].valid) state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    occ_next = occ;
    if (insert && !full) occ_next = occ + OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
      occ   <= '0;
    end else begin
      state <= state_next;
      go    <= req_fire;
      occ   <= occ_next;
    end
  end

  // request latch and final probe capture
  always_ff @(posedge clk) begin
    if (req_fire) begin
      key_r   <= req.font_number;
      fresh_r <= req.fresh_handle;
      ok_r    <= req.open_ok;
    end
    if (probe[ENTRIES].valid) fin <= probe[ENTRIES];
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.hit            <= fin.hit;
      rsp.failed         <= !fin.hit && !ok_r;
      rsp.evict_valid    <= insert && full;
      rsp.evicted_handle <= (insert && full) ? cell_handle[0] : '0;
      if (fin.hit)     rsp.handle_out <= fin.handle;
      else if (ok_r)   rsp.handle_out <= fresh_r;
      else             rsp.handle_out <= '0;
    end
  end

  // checks
  a_launch: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> go && (state == S_WALK))
    else $error("probe not launched after request");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(ENTRIES))
    else $error("occupancy above table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !out_load)
    else $error("pending response overwritten");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    out_load && insert && full |=> rsp.valid && rsp.evict_valid && (occ == OCC_W'(ENTRIES)))
    else $error("eviction state mismatch");

  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && (rsp.failed || rsp.evict_valid)))
    else $error("hit flagged with failure or eviction");

endmodule

FILE: tb/tb_fifo_handle_cache_core.sv
// ----------------------------------------------------------------------------
// tb_fifo_handle_cache_core: self-checking bench for the font handle cache
// A directed opening walks the empty, partly filled and full table, then
// randomized requests draw keys from small rotating pools so that hits,
// fills, FIFO replacements and failed opens all occur often. A queue-based
// model of the table predicts every response, and a monitor checks each one
// against it. Request bursts, response stalls and one long output hold-off
// exercise backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_fifo_handle_cache_core;
  import fhc_pkg::*;

  localparam int N_ENTRIES  = DEFAULT_ENTRIES;
  localparam int N_RANDOM   = 1900;
  localparam int CYCLE_CAP  = 500000;
  localparam int DRAIN_CYC  = 3 * (N_ENTRIES + 3);
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [KEY_W-1:0]    font_number;
    logic [HANDLE_W-1:0] fresh_handle;
    logic                open_ok;
  } font_req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic                failed;
    logic                evict_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } font_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } cache_slot_t;

  logic clk;
  logic rst;

  fhc_req_if req_ch ();
  fhc_rsp_if rsp_ch ();

  fifo_handle_cache_core #(
    .ENTRIES (N_ENTRIES)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // request stream, predicted table contents and outstanding responses
  font_req_t   pending_req_q[$];
  cache_slot_t cached_q[$];       // oldest first
  font_rsp_t   expected_rsp_q[$];

  font_req_t   cur_req;
  int          burst_left;
  int          gap_left;
  int          req_acc_cnt;
  int          rsp_cnt;
  int          err_cnt;
  int          n_hit, n_fill, n_replace, n_fail;
  int          hold_left;
  bit          hold_done;
  logic [15:0] stall_pat;
  int          pat_age;
  int          cycle_cnt;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // table model: lookup from the oldest entry, fill, or replace the oldest
  function automatic font_rsp_t cache_lookup(input font_req_t r);
    font_rsp_t   res;
    cache_slot_t dropped;
    int          idx;
    res = '0;
    idx = -1;
    foreach (cached_q[i])
      if (idx < 0 && cached_q[i].key == r.font_number) idx = i;
    if (idx >= 0) begin
      res.hit        = 1'b1;
      res.handle_out = cached_q[idx].handle;
    end else if (!r.open_ok) begin
      res.failed = 1'b1;
    end else begin
      if (cached_q.size() >= N_ENTRIES) begin
        dropped            = cached_q.pop_front();
        res.evict_valid    = 1'b1;
        res.evicted_handle = dropped.handle;
      end
      cached_q.push_back('{key: r.font_number, handle: r.fresh_handle});
      res.handle_out = r.fresh_handle;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at response %0d: %s", rsp_cnt, msg);
    err_cnt++;
  endtask

  task automatic add_req(input logic [KEY_W-1:0] key, input logic [HANDLE_W-1:0] h,
                         input logic ok);
    pending_req_q.push_back('{font_number: key, fresh_handle: h, open_ok: ok});
  endtask

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid        <= 1'b0;
      req_ch.font_number  <= '0;
      req_ch.fresh_handle <= '0;
      req_ch.open_ok      <= 1'b0;
      burst_left          <= 0;
      gap_left            <= 0;
      req_acc_cnt         <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp_q.push_back(cache_lookup(cur_req));
        req_acc_cnt <= req_acc_cnt + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          cur_req              = pending_req_q.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.font_number  <= cur_req.font_number;
          req_ch.fresh_handle <= cur_req.fresh_handle;
          req_ch.open_ok      <= cur_req.open_ok;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // about one burst in four ends with no gap at all
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long output hold-off so the core backs up into the request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && req_acc_cnt == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor and stall pattern
  always @(posedge clk) begin
    font_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_pat    <= 16'hFFFF;
      pat_age      <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with nothing outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (want.hit) n_hit++;
          else if (want.failed) n_fail++;
          else if (want.evict_valid) n_replace++;
          else n_fill++;
          if (rsp_ch.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", rsp_ch.hit, want.hit));
          if (rsp_ch.handle_out !== want.handle_out)
            report_mismatch($sformatf("handle_out %h, want %h",
                                      rsp_ch.handle_out, want.handle_out));
          if (rsp_ch.failed !== want.failed)
            report_mismatch($sformatf("failed %b, want %b", rsp_ch.failed, want.failed));
          if (rsp_ch.evict_valid !== want.evict_valid)
            report_mismatch($sformatf("evict_valid %b, want %b",
                                      rsp_ch.evict_valid, want.evict_valid));
          if (rsp_ch.evicted_handle !== want.evicted_handle)
            report_mismatch($sformatf("evicted_handle %h, want %h",
                                      rsp_ch.evicted_handle, want.evicted_handle));
        end
        rsp_cnt++;
      end
      // new pattern each time pat_age wraps; about a quarter of them never stall
      if (pat_age == 63) begin
        pat_age   <= 0;
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                     (16'($urandom()) | (16'h0001 << $urandom_range(0, 15)));
      end else begin
        pat_age   <= pat_age + 1;
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
      end
      rsp_ch.ready <= (hold_left == 0) && stall_pat[0];
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[fifo_handle_cache_core] ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [KEY_W-1:0] key_pool[16];
    int               pool_n;
    logic [KEY_W-1:0] key;

    rst                 = 1'b1;
    cycle_cnt           = 0;
    err_cnt             = 0;
    rsp_cnt             = 0;
    n_hit               = 0;
    n_fill              = 0;
    n_replace           = 0;
    n_fail              = 0;
    req_ch.valid        = 1'b0;
    req_ch.font_number  = '0;
    req_ch.fresh_handle = '0;
    req_ch.open_ok      = 1'b0;
    rsp_ch.ready        = 1'b0;

    // directed: failed open on empty table, fill, hit, full table,
    // failed open on full table, replacement, re-miss on a dropped key
    add_req(32'h0000_0000, 16'h0000, 1'b0);
    add_req(32'h0000_0000, 16'hFFFF, 1'b1);
    add_req(32'h0000_0000, 16'h1234, 1'b0);  // hit wins over failed open
    add_req(32'hFFFF_FFFF, 16'h0000, 1'b1);
    for (int k = 1; k <= 6; k++) add_req(KEY_W'(k), HANDLE_W'(16'h0100 + k), 1'b1);
    add_req(32'h0000_0000, 16'h4321, 1'b1);  // hit on the oldest entry
    add_req(32'hFFFF_FFFF, 16'h0BAD, 1'b1);
    add_req(32'h0000_0007, 16'hAAAA, 1'b0);  // failed open, table full
    add_req(32'h0000_0008, 16'h5555, 1'b1);  // drops key 0
    add_req(32'h0000_0000, 16'h0001, 1'b1);  // drops all-ones key
    add_req(32'hFFFF_FFFF, 16'hFFFE, 1'b0);  // dropped key now fails
    add_req(32'h0000_0006, 16'h0000, 1'b1);
    add_req(32'h0000_0008, 16'h0000, 1'b1);
    add_req(32'h0000_0000, 16'h0000, 1'b1);

    // random: keys from a small pool per segment so hits and replacements mix
    pool_n = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        pool_n = $urandom_range(4, 16);
        foreach (key_pool[i]) key_pool[i] = $urandom();
      end
      if ($urandom_range(0, 9) == 0) key = $urandom();
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      add_req(key, 16'($urandom()), $urandom_range(0, 6) != 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_req_q.size() > 0 || req_ch.valid) @(posedge clk);
    while (expected_rsp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (expected_rsp_q.size() > 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));
    $display("checked %0d responses: %0d hits, %0d fills, %0d replacements, %0d failed opens",
             rsp_cnt, n_hit, n_fill, n_replace, n_fail);
    $display("bursty requests, patterned response stalls and a %0d-cycle output hold-off",
             HOLD_LEN);
    if (err_cnt == 0) begin
      $display("[fifo_handle_cache_core] OK");
    end else begin
      $display("[fifo_handle_cache_core] ERROR");
    end
    $finish;
  end

endmodule
